### sv/chxy_pkg.sv
// Package with the shared types, codes and the XY step function of the hierarchical router.
package chxy_pkg;

    localparam int MESH_SIZE       = 16;
    localparam int CHIPLET_ROUTERS = 64;

    typedef enum logic [2:0] {
        DIR_EAST     = 3'd0,
        DIR_WEST     = 3'd1,
        DIR_NORTH    = 3'd2,
        DIR_SOUTH    = 3'd3,
        DIR_UP       = 3'd4,
        DIR_DOWN     = 3'd5,
        DIR_MEM_UP   = 3'd6,
        DIR_MEM_DOWN = 3'd7
    } dir_t;

    typedef enum logic [1:0] {
        ST_ROUTED  = 2'd0,
        ST_HERE    = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    localparam logic CFG_THIS_ROUTER_ID = 1'b0;
    localparam logic CFG_ROUTER_COUNT   = 1'b1;

    typedef struct packed {
        logic [7:0] this_router_id;
        logic [8:0] router_count;
    } cfg_t;

    typedef struct packed {
        dir_t    direction;
        status_t status;
    } route_t;

    // One dimension-order step. The source index may lie far above the mesh
    // when this router's id is beyond the router count, so its row is wide.
    function automatic dir_t xy_step(input logic [8:0] from_local, input logic [3:0] to_local);
        logic [1:0] fx;
        logic [6:0] fy;
        logic [1:0] tx;
        logic [6:0] ty;
        dir_t       dir;
        fx = from_local[1:0];
        fy = from_local[8:2];
        tx = to_local[1:0];
        ty = {5'b00000, to_local[3:2]};
        if (tx != fx)
        begin
            dir = (tx > fx) ? DIR_EAST : DIR_WEST;
        end
        else if (ty > fy)
        begin
            dir = DIR_NORTH;
        end
        else if (ty < fy)
        begin
            dir = DIR_SOUTH;
        end
        else
        begin
            dir = DIR_EAST;
        end
        return dir;
    endfunction

endpackage

### sv/chxy_route.sv
// Combinational route computation for one destination id.
module chxy_route
    import chxy_pkg::*;
(
    input  cfg_t       cfg,
    input  logic [7:0] dest_id,
    output route_t     route
);

    logic signed [9:0] base;
    logic signed [9:0] me_ext;
    logic        [9:0] ip_local_wide;
    logic        [8:0] ip_local;
    logic        [9:0] mem_target;
    logic        [3:0] chip_target;
    logic        [3:0] border;
    logic              is_interposer;
    logic              dest_out_of_range;

    assign base              = $signed({1'b0, cfg.router_count}) - 10'sd16;
    assign me_ext            = $signed({2'b00, cfg.this_router_id});
    assign is_interposer     = (me_ext >= base);
    assign ip_local_wide     = 10'(me_ext - base);
    assign ip_local          = ip_local_wide[8:0];
    assign mem_target        = {2'b00, dest_id} - {1'b0, cfg.router_count} + 10'd32;
    assign chip_target       = {dest_id[5], dest_id[3], dest_id[4], dest_id[1]};
    assign border            = {cfg.this_router_id[3], cfg.this_router_id[3],
                                cfg.this_router_id[1], ~cfg.this_router_id[1]};
    assign dest_out_of_range = ({1'b0, dest_id} >= cfg.router_count);

    always_comb
    begin
        route.direction = DIR_EAST;
        route.status    = ST_ROUTED;
        priority if (dest_out_of_range)
        begin
            route.status = ST_INVALID;
        end
        else if (dest_id == cfg.this_router_id)
        begin
            route.status = ST_HERE;
        end
        else if (is_interposer)
        begin
            if (dest_id[7:6] == 2'b00)
            begin
                if ({5'b00000, chip_target} == ip_local)
                begin
                    route.direction = DIR_UP;
                end
                else
                begin
                    route.direction = xy_step(ip_local, chip_target);
                end
            end
            else if (mem_target[9:4] != 6'd0)
            begin
                route.status = ST_INVALID;
            end
            else if ({5'b00000, mem_target[3:0]} == ip_local)
            begin
                route.direction = DIR_MEM_UP;
            end
            else
            begin
                route.direction = xy_step(ip_local, mem_target[3:0]);
            end
        end
        else if (cfg.this_router_id[7:6] == 2'b00)
        begin
            if (cfg.this_router_id[7:4] != dest_id[7:4])
            begin
                if (border == cfg.this_router_id[3:0])
                begin
                    route.direction = DIR_DOWN;
                end
                else
                begin
                    route.direction = xy_step({5'b00000, cfg.this_router_id[3:0]}, border);
                end
            end
            else
            begin
                route.direction = xy_step({5'b00000, cfg.this_router_id[3:0]},
                                          dest_id[3:0]);
            end
        end
        else
        begin
            route.direction = DIR_MEM_DOWN;
        end
    end

endmodule

### sv/chiplet_hierarchical_xy_route.sv
// Top level of the hierarchical chiplet XY route computation with its pipeline registers.

// One destination id is accepted per cycle and held in the input register. The route logic
// feeds its direction and status to the result register, which loads them once it is empty
// or its result is taken. The input stalls only when both registers hold a beat and the
// result is not taken. Configuration is written through a plain write port; the user must
// write it only while no beat is in flight, and the block itself does not enforce this.
module chiplet_hierarchical_xy_route
    import chxy_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [8:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] dest_id,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] direction,
    output logic [1:0] status
);

    cfg_t       cfg_reg;
    logic       s1_valid_reg;
    logic [7:0] s1_dest_reg;
    logic       out_valid_reg;
    route_t     route_reg;
    route_t     route_next;
    logic       s2_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.this_router_id <= 8'd0;
            cfg_reg.router_count   <= 9'd88;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THIS_ROUTER_ID: cfg_reg.this_router_id <= cfg_data[7:0];
                CFG_ROUTER_COUNT:   cfg_reg.router_count   <= cfg_data;
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    assign s2_en    = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s2_en;

    chxy_route u_route
    (
        .cfg     (cfg_reg),
        .dest_id (s1_dest_reg),
        .route   (route_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_en)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_dest_reg <= dest_id;
        end
        if (s2_en && s1_valid_reg)
        begin
            route_reg <= route_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign direction = route_reg.direction;
    assign status    = route_reg.status;

    a_dir_zero_unless_routed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (route_reg.status != ST_ROUTED)) |-> (route_reg.direction == DIR_EAST))
        else $error("direction is not zero on a beat that is not routed");

    a_stage1_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_en) |=> (s1_valid_reg && $stable(s1_dest_reg)))
        else $error("input stage lost its beat during an output stall");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input not ready although the result register is empty");

endmodule
